// ===== rtl/software_timer_expiry_queue_core_assert.svh =====
// Assertion macros shared by the timer queue modules.
`ifndef SOFTWARE_TIMER_EXPIRY_QUEUE_CORE_ASSERT_SVH
`define SOFTWARE_TIMER_EXPIRY_QUEUE_CORE_ASSERT_SVH

// Check that a condition holds at every edge out of reset.
`define STQ_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a condition at one edge implies another at the next edge.
`define STQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/stq_pkg.sv =====
`default_nettype none
package stq_pkg;
   localparam int STQ_CAPACITY = 16;

   localparam logic       KIND_TICK = 1'b0;
   localparam logic       KIND_ADD  = 1'b1;

   localparam logic [1:0] RES_EXPIRED = 2'd0;
   localparam logic [1:0] RES_DONE    = 2'd1;
   localparam logic [1:0] RES_REJECT  = 2'd2;

   localparam logic [7:0] CSR_MARKER = 8'd0;
   localparam logic [7:0] CSR_PERIOD = 8'd1;

   typedef struct packed {
      logic       start_tick;   // advance tick, load budget, clear switch flag
      logic       insert_new;   // insert the accepted add word
      logic       pop_head;     // take head into hold, shrink store
      logic       insert_rearm; // insert held re-arm timer
      logic       rsp_load;     // load result register
      logic [1:0] rsp_kind;
   } stq_cmd_type;

   typedef struct packed {
      logic full;
      logic head_due;
      logic hold_marker;
      logic rsp_free;
   } stq_status_type;
endpackage
`default_nettype wire

// ===== rtl/stq_ctrl.sv =====
`default_nettype none
module stq_ctrl
   import stq_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   input  wire logic           req_kind,
   output logic                req_tready,
   input  wire stq_status_type status,
   output stq_cmd_type         cmd
);
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CHECK  = 6'b000010,
      ST_EMIT   = 6'b000100,
      ST_REARM  = 6'b001000,
      ST_DONE   = 6'b010000,
      ST_REJECT = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_TICK) begin
                  cmd.start_tick = 1'b1;
                  state_in       = ST_CHECK;
               end else if (status.full) begin
                  state_in = ST_REJECT;
               end else begin
                  cmd.insert_new = 1'b1;
               end
            end
         end
         ST_CHECK: begin
            if (status.head_due) begin
               cmd.pop_head = 1'b1;
               state_in     = ST_EMIT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_EMIT: begin
            // held timer is either re-armed silently or reported
            if (status.hold_marker) begin
               state_in = ST_REARM;
            end else if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = RES_EXPIRED;
               state_in     = ST_CHECK;
            end
         end
         ST_REARM: begin
            cmd.insert_rearm = 1'b1;
            state_in         = ST_CHECK;
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = RES_DONE;
               state_in     = ST_IDLE;
            end
         end
         ST_REJECT: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = RES_REJECT;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`include "software_timer_expiry_queue_core_assert.svh"
   `STQ_ASSERT_ALWAYS(a_no_insert_when_full, !(cmd.insert_new && status.full), "insert into full store")
   `STQ_ASSERT_NEXT(a_rearm_follows_marker, (state_ff == ST_REARM), (state_ff == ST_CHECK), "re-arm did not return to check")
endmodule
`default_nettype wire

// ===== rtl/stq_datapath.sv =====
`default_nettype none
module stq_datapath
   import stq_pkg::*;
#(
   parameter int CAPACITY = STQ_CAPACITY
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire stq_cmd_type   cmd,
   output stq_status_type     status,
   input  wire logic [63:0]   new_deadline,
   input  wire logic [31:0]   new_value,
   input  wire logic [63:0]   new_task_id,
   input  wire logic          csr_we,
   input  wire logic [7:0]    csr_index,
   input  wire logic [31:0]   csr_wdata,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [1:0]         rsp_kind,
   output logic [63:0]        rsp_deadline,
   output logic [31:0]        rsp_value,
   output logic [63:0]        rsp_task_id,
   output logic               rsp_switch,
   output logic               rsp_last
);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [63:0]      dl_ff  [CAPACITY];
   logic [31:0]      val_ff [CAPACITY];
   logic [63:0]      tid_ff [CAPACITY];
   logic [CNT_W-1:0] occ_ff, budget_ff;
   logic [63:0]      tick_ff, tick_in;
   logic [31:0]      marker_ff, period_ff;
   logic [63:0]      hold_dl_ff, rearm_ff;
   logic [31:0]      hold_val_ff;
   logic [63:0]      hold_tid_ff;
   logic             sw_ff;
   logic             rsp_valid_ff;
   logic [1:0]       rsp_kind_ff;
   logic [63:0]      rsp_dl_ff, rsp_tid_ff;
   logic [31:0]      rsp_val_ff;
   logic             rsp_sw_ff, rsp_last_ff;

   logic             ins;
   logic [63:0]      ins_dl, ins_tid;
   logic [31:0]      ins_val;
   logic [CAPACITY-1:0] le;
   logic [64:0]      rearm_sum;
   logic [31:0]      period_eff;
   logic             rsp_free;

   assign ins     = cmd.insert_new || cmd.insert_rearm;
   assign ins_dl  = cmd.insert_rearm ? rearm_ff : new_deadline;
   assign ins_val = cmd.insert_rearm ? marker_ff : new_value;
   assign ins_tid = cmd.insert_rearm ? 64'd1 : new_task_id;

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         le[i] = (CNT_W'(i) < occ_ff) && (dl_ff[i] <= ins_dl);
      end
   end

   assign tick_in    = tick_ff + 64'd1;
   assign period_eff = (period_ff == 32'd0) ? 32'd1 : period_ff;
   assign rearm_sum  = {1'b0, tick_ff} + {33'd0, period_eff};
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   assign status.full        = (occ_ff == CNT_W'(CAPACITY));
   assign status.head_due    = (budget_ff != '0) && (occ_ff != '0) && (dl_ff[0] <= tick_ff);
   assign status.hold_marker = (hold_val_ff == marker_ff);
   assign status.rsp_free    = rsp_free;

   // sorted row of cells: insert after not-later entries, pop shifts down
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      always_ff @(posedge clock) begin
         if (ins) begin
            if (!le[i]) begin
               if (i == 0) begin
                  dl_ff[i]  <= ins_dl;
                  val_ff[i] <= ins_val;
                  tid_ff[i] <= ins_tid;
               end else if (le[(i == 0) ? 0 : i - 1]) begin
                  dl_ff[i]  <= ins_dl;
                  val_ff[i] <= ins_val;
                  tid_ff[i] <= ins_tid;
               end else begin
                  dl_ff[i]  <= dl_ff[(i == 0) ? 0 : i - 1];
                  val_ff[i] <= val_ff[(i == 0) ? 0 : i - 1];
                  tid_ff[i] <= tid_ff[(i == 0) ? 0 : i - 1];
               end
            end
         end else if (cmd.pop_head && (i < CAPACITY - 1)) begin
            dl_ff[i]  <= dl_ff[(i < CAPACITY - 1) ? i + 1 : i];
            val_ff[i] <= val_ff[(i < CAPACITY - 1) ? i + 1 : i];
            tid_ff[i] <= tid_ff[(i < CAPACITY - 1) ? i + 1 : i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         budget_ff    <= '0;
         tick_ff      <= '0;
         marker_ff    <= 32'h8000_0000;
         period_ff    <= 32'd2;
         sw_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_MARKER: marker_ff <= csr_wdata;
               CSR_PERIOD: period_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.start_tick) begin
            tick_ff   <= tick_in;
            budget_ff <= occ_ff;
            sw_ff     <= 1'b0;
         end
         if (ins) begin
            occ_ff <= occ_ff + CNT_W'(1);
         end else if (cmd.pop_head) begin
            occ_ff    <= occ_ff - CNT_W'(1);
            budget_ff <= budget_ff - CNT_W'(1);
         end
         if (cmd.insert_rearm) begin
            sw_ff <= 1'b1;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.pop_head) begin
         hold_dl_ff  <= dl_ff[0];
         hold_val_ff <= val_ff[0];
         hold_tid_ff <= tid_ff[0];
         rearm_ff    <= rearm_sum[64] ? {64{1'b1}} : rearm_sum[63:0];
      end
      if (cmd.rsp_load) begin
         rsp_kind_ff <= cmd.rsp_kind;
         rsp_sw_ff   <= (cmd.rsp_kind == RES_DONE) && sw_ff;
         rsp_last_ff <= (cmd.rsp_kind != RES_EXPIRED);
         if (cmd.rsp_kind == RES_EXPIRED) begin
            rsp_dl_ff  <= hold_dl_ff;
            rsp_val_ff <= hold_val_ff;
            rsp_tid_ff <= hold_tid_ff;
         end else begin
            rsp_dl_ff  <= '0;
            rsp_val_ff <= '0;
            rsp_tid_ff <= '0;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_deadline = rsp_dl_ff;
   assign rsp_value    = rsp_val_ff;
   assign rsp_task_id  = rsp_tid_ff;
   assign rsp_switch   = rsp_sw_ff;
   assign rsp_last     = rsp_last_ff;

`include "software_timer_expiry_queue_core_assert.svh"
   `STQ_ASSERT_ALWAYS(a_occ_bound, (occ_ff <= CNT_W'(CAPACITY)), "occupancy above capacity")
   `STQ_ASSERT_ALWAYS(a_budget_bound, (budget_ff <= occ_ff) || !cmd.pop_head, "budget exceeds store")
   `STQ_ASSERT_NEXT(a_pop_shrinks, (cmd.pop_head && !ins), (occ_ff == $past(occ_ff) - CNT_W'(1)), "pop did not shrink store")
endmodule
`default_nettype wire

// ===== rtl/software_timer_expiry_queue_core.sv =====
// Channel | Direction | Handshake              | Word
// req     | in        | req_tvalid/req_tready  | tuser kind, tdata add timer fields
// rsp     | out       | rsp_tvalid/rsp_tready  | tuser result kind, tlast end of run
// csr     | in        | csr_valid/csr_ready    | register index and write data
//
// An add is inserted when it is accepted; a rejected add goes to a reject state,
// which loads the reject word once the output register is free. A tick runs the
// head compare / pop / report sequence of the controller: each due head is popped
// and reported, or re-armed if it is a task-switch timer, and a done word ends it.
// Reset clears the tick counter and empties the store; no clearing pass runs.
// A stalled result holds the controller only where it must load the next word.
`default_nettype none
module software_timer_expiry_queue_core
   import stq_pkg::*;
#(
   parameter int CAPACITY = STQ_CAPACITY
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [0:0]   req_tuser,  // kind
   input  wire logic [159:0] req_tdata,  // new_deadline, new_value, new_task_id
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [1:0]        rsp_tuser,  // result_kind
   output logic [167:0]      rsp_tdata,  // expired_deadline, expired_value,
                                         // expired_task_id, switch_task, zero pad
   output logic              rsp_tlast,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [7:0]   csr_index,
   input  wire logic [31:0]  csr_wdata
);
   stq_cmd_type    cmd;
   stq_status_type status;
   logic [63:0]    rsp_deadline, rsp_task_id;
   logic [31:0]    rsp_value;
   logic           rsp_switch;

   // registers take a word whenever offered
   assign csr_ready = 1'b1;

   stq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser[0]),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   stq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .new_deadline (req_tdata[63:0]),
      .new_value    (req_tdata[95:64]),
      .new_task_id  (req_tdata[159:96]),
      .csr_we       (csr_valid && csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_kind     (rsp_tuser),
      .rsp_deadline (rsp_deadline),
      .rsp_value    (rsp_value),
      .rsp_task_id  (rsp_task_id),
      .rsp_switch   (rsp_switch),
      .rsp_last     (rsp_tlast)
   );

   assign rsp_tdata = {7'd0, rsp_switch, rsp_task_id, rsp_value, rsp_deadline};
endmodule
`default_nettype wire
